### design/ksqt_pkg.sv
// ----------------------------------------------------------------------------
// ksqt_pkg
// Shared sizes, request codes and controller/datapath interface structs for
// the keyed stack/queue table.
// ----------------------------------------------------------------------------
package ksqt_pkg;

   // Store size and derived widths
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int OCC_W   = 5;
   localparam int FUNC_W  = 2;

   // Request codes
   localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
   localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd3;

   // Returned id when nothing was taken out
   localparam logic [WORD_W-1:0] NONE_ID = '1;

   // Controller -> datapath commands
   typedef struct packed {
      logic start;    // latch request word, clear scan pointer
      logic push;     // insert at front
      logic append;   // insert at back
      logic take;     // remove entry at scan pointer and close the gap
      logic step;     // advance scan pointer
      logic finish;   // load result register
      logic ovf;      // result carries the overflow flag
   } ksqt_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              empty;
      logic              match;   // entry at scan pointer has the searched id
      logic              last;    // scan pointer is on the last held entry
   } ksqt_status_type;

endpackage

### design/ksqt_dp.sv
// ----------------------------------------------------------------------------
// ksqt_dp
// Datapath: entry registers, count, scan pointer, latched request and the
// result register.
// ----------------------------------------------------------------------------
module ksqt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ksqt_pkg::ksqt_cmd_type              cmd,
   output ksqt_pkg::ksqt_status_type           status,
   input  logic [ksqt_pkg::FUNC_W-1:0]         req_func,
   input  logic [ksqt_pkg::WORD_W-1:0]         req_key_id,
   input  logic [ksqt_pkg::WORD_W-1:0]         req_price_bits,
   output logic                                rsp_hit,
   output logic [ksqt_pkg::WORD_W-1:0]         rsp_out_id,
   output logic [ksqt_pkg::WORD_W-1:0]         rsp_out_price_bits,
   output logic                                rsp_overflow,
   output logic [ksqt_pkg::OCC_W-1:0]          rsp_occupancy
);

   logic [ksqt_pkg::WORD_W-1:0] ids_ff    [ksqt_pkg::DEPTH];
   logic [ksqt_pkg::WORD_W-1:0] ids_in    [ksqt_pkg::DEPTH];
   logic [ksqt_pkg::WORD_W-1:0] prices_ff [ksqt_pkg::DEPTH];
   logic [ksqt_pkg::WORD_W-1:0] prices_in [ksqt_pkg::DEPTH];
   logic [ksqt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ksqt_pkg::IDX_W-1:0]  scan_ff, scan_in;
   logic [ksqt_pkg::FUNC_W-1:0] func_ff;
   logic [ksqt_pkg::WORD_W-1:0] key_ff, price_ff;
   logic [ksqt_pkg::WORD_W-1:0] scan_id, scan_price;
   logic [ksqt_pkg::CNT_W-1:0]  scan_next;

   // Entry under the scan pointer
   assign scan_id    = ids_ff[scan_ff];
   assign scan_price = prices_ff[scan_ff];
   assign scan_next  = ksqt_pkg::CNT_W'(scan_ff) + ksqt_pkg::CNT_W'(1);

   // Status to the controller
   assign status.func  = func_ff;
   assign status.full  = (count_ff >= ksqt_pkg::CNT_W'(ksqt_pkg::DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.match = (scan_id == key_ff);
   assign status.last  = (scan_next >= count_ff);

   // Entry row: each entry takes its own value, a neighbor or the new word
   always_comb begin
      for (int i = 0; i < ksqt_pkg::DEPTH; i++) begin
         ids_in[i]    = ids_ff[i];
         prices_in[i] = prices_ff[i];
         if (cmd.push) begin
            if (i == 0) begin
               ids_in[i]    = key_ff;
               prices_in[i] = price_ff;
            end else begin
               ids_in[i]    = ids_ff[(i + ksqt_pkg::DEPTH - 1) % ksqt_pkg::DEPTH];
               prices_in[i] = prices_ff[(i + ksqt_pkg::DEPTH - 1) % ksqt_pkg::DEPTH];
            end
         end else if (cmd.append) begin
            if (ksqt_pkg::CNT_W'(i) == count_ff) begin
               ids_in[i]    = key_ff;
               prices_in[i] = price_ff;
            end
         end else if (cmd.take) begin
            if ((i < ksqt_pkg::DEPTH - 1) && (ksqt_pkg::IDX_W'(i) >= scan_ff)) begin
               ids_in[i]    = ids_ff[(i + 1) % ksqt_pkg::DEPTH];
               prices_in[i] = prices_ff[(i + 1) % ksqt_pkg::DEPTH];
            end
         end
      end
   end

   // Count and scan pointer
   always_comb begin
      count_in = count_ff;
      if (cmd.push || cmd.append) begin
         count_in = count_ff + ksqt_pkg::CNT_W'(1);
      end else if (cmd.take) begin
         count_in = count_ff - ksqt_pkg::CNT_W'(1);
      end
      scan_in = scan_ff;
      if (cmd.start) begin
         scan_in = '0;
      end else if (cmd.step) begin
         scan_in = scan_ff + ksqt_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      ids_ff    <= ids_in;
      prices_ff <= prices_in;
      scan_ff   <= scan_in;
      if (cmd.start) begin
         func_ff  <= req_func;
         key_ff   <= req_key_id;
         price_ff <= req_price_bits;
      end
      if (cmd.finish) begin
         rsp_hit            <= cmd.take;
         rsp_out_id         <= cmd.take ? scan_id : ksqt_pkg::NONE_ID;
         rsp_out_price_bits <= cmd.take ? scan_price : '0;
         rsp_overflow       <= cmd.ovf;
         rsp_occupancy      <= ksqt_pkg::OCC_W'(count_in);
      end
   end

endmodule

### design/ksqt_ctrl.sv
// ----------------------------------------------------------------------------
// ksqt_ctrl
// Controller: request handshake, per-request sequencing and result valid.
// ----------------------------------------------------------------------------
module ksqt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  ksqt_pkg::ksqt_status_type   status,
   output ksqt_pkg::ksqt_cmd_type      cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Sequencing: one remove scan step per cycle while result is free
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               case (status.func)
                  ksqt_pkg::FN_PUSH, ksqt_pkg::FN_APPEND: begin
                     cmd.finish = 1'b1;
                     if (status.full) begin
                        cmd.ovf = 1'b1;
                     end else if (status.func == ksqt_pkg::FN_PUSH) begin
                        cmd.push = 1'b1;
                     end else begin
                        cmd.append = 1'b1;
                     end
                  end
                  ksqt_pkg::FN_POP: begin
                     cmd.finish = 1'b1;
                     cmd.take   = !status.empty;
                  end
                  default: begin
                     if (status.empty) begin
                        cmd.finish = 1'b1;
                     end else if (status.match) begin
                        cmd.take   = 1'b1;
                        cmd.finish = 1'b1;
                     end else if (status.last) begin
                        cmd.finish = 1'b1;
                     end else begin
                        cmd.step = 1'b1;
                     end
                  end
               endcase
               if (cmd.finish) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid: set on finish, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/keyed_stack_queue_table.sv
// ----------------------------------------------------------------------------
// keyed_stack_queue_table
// Ordered store of id/price entries with push front, append back, pop front
// and remove-by-id.
// ----------------------------------------------------------------------------
// A request word is accepted in the idle state and executed in the execute
// state. Remove-by-id walks the held entries from the front, one compare per
// cycle while the result register is free, until the match or the last held
// entry; a single comparator on the scan pointer does the walk. A new request
// is taken while the previous result still waits on rsp_ready, but not while
// the previous request executes; its execution holds until the result register
// is free. No clearing pass runs after reset: the block is ready as soon as
// reset drops.
// ----------------------------------------------------------------------------
module keyed_stack_queue_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ksqt_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [ksqt_pkg::WORD_W-1:0]  req_key_id,
   input  logic [ksqt_pkg::WORD_W-1:0]         req_price_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic signed [ksqt_pkg::WORD_W-1:0]  rsp_out_id,
   output logic [ksqt_pkg::WORD_W-1:0]         rsp_out_price_bits,
   output logic                                rsp_overflow,
   output logic [ksqt_pkg::OCC_W-1:0]          rsp_occupancy
);

   ksqt_pkg::ksqt_cmd_type    cmd;
   ksqt_pkg::ksqt_status_type status;
   logic [ksqt_pkg::WORD_W-1:0] out_id;

   assign rsp_out_id = $signed(out_id);

   ksqt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ksqt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_key_id         ($unsigned(req_key_id)),
      .req_price_bits     (req_price_bits),
      .rsp_hit            (rsp_hit),
      .rsp_out_id         (out_id),
      .rsp_out_price_bits (rsp_out_price_bits),
      .rsp_overflow       (rsp_overflow),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

### design/ksqt_checker.sv
// ----------------------------------------------------------------------------
// ksqt_checker
// Port-level checks for the keyed stack/queue table, bound to the top level.
// ----------------------------------------------------------------------------
module ksqt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_hit,
   input logic signed [ksqt_pkg::WORD_W-1:0]  rsp_out_id,
   input logic [ksqt_pkg::WORD_W-1:0]         rsp_out_price_bits,
   input logic                                rsp_overflow,
   input logic [ksqt_pkg::OCC_W-1:0]          rsp_occupancy
);

   // Stalled result word holds its hit, id, price and occupancy fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_out_id)
         && $stable(rsp_out_price_bits) && $stable(rsp_occupancy))
      else $error("result word changed while stalled");

   // A miss or insert returns the empty entry
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_out_id == -1) && (rsp_out_price_bits == '0))
      else $error("miss result carries entry data");

   // Hit and overflow never come together
   a_hit_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_overflow))
      else $error("hit and overflow both set");

   // Overflow only when the store is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_occupancy == ksqt_pkg::OCC_W'(ksqt_pkg::DEPTH))
      else $error("overflow reported with room left");

   // One request in flight: accept closes the input until it executes
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted before execution");

endmodule

bind keyed_stack_queue_table ksqt_checker u_ksqt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_hit            (rsp_hit),
   .rsp_out_id         (rsp_out_id),
   .rsp_out_price_bits (rsp_out_price_bits),
   .rsp_overflow       (rsp_overflow),
   .rsp_occupancy      (rsp_occupancy)
);

### sim/ksqt_table_checker.sv
// ----------------------------------------------------------------------------
// ksqt_table_checker
// Watches the request and result channels of the keyed stack/queue table,
// keeps its own copy of the ordered store, predicts one result word per
// accepted request and compares every accepted result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ksqt_table_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [ksqt_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [ksqt_pkg::WORD_W-1:0]  req_key_id,
   input  logic [ksqt_pkg::WORD_W-1:0]         req_price_bits,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_hit,
   input  logic signed [ksqt_pkg::WORD_W-1:0]  rsp_out_id,
   input  logic [ksqt_pkg::WORD_W-1:0]         rsp_out_price_bits,
   input  logic                                rsp_overflow,
   input  logic [ksqt_pkg::OCC_W-1:0]          rsp_occupancy,
   output int                                  fail_count,
   output int                                  outstanding
);

   // One predicted result word
   typedef struct {
      logic                        hit;
      logic [ksqt_pkg::WORD_W-1:0] id;
      logic [ksqt_pkg::WORD_W-1:0] price;
      logic                        ovf;
      logic [ksqt_pkg::OCC_W-1:0]  occ;
   } table_result_type;

   // Shadow store, front at position 0
   logic [ksqt_pkg::WORD_W-1:0] held_ids    [ksqt_pkg::DEPTH];
   logic [ksqt_pkg::WORD_W-1:0] held_prices [ksqt_pkg::DEPTH];
   int                          held_count;

   table_result_type  pending_results [$];
   table_result_type  want;
   int                rsp_index;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      held_count  = 0;
      rsp_index   = 0;
   end

   task automatic report(input string msg);
      if (fail_count < 100) begin
         $display("[%0t] checker: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Take out the entry at pos and close the gap behind it
   function automatic void take_entry(input int pos, inout table_result_type res);
      int i;
      res.hit   = 1'b1;
      res.id    = held_ids[pos];
      res.price = held_prices[pos];
      for (i = pos; i + 1 < held_count; i++) begin
         held_ids[i]    = held_ids[i + 1];
         held_prices[i] = held_prices[i + 1];
      end
      held_count--;
   endfunction

   // Apply one request to the shadow store and return its result word
   function automatic table_result_type apply_request(
         input logic [ksqt_pkg::FUNC_W-1:0] func,
         input logic [ksqt_pkg::WORD_W-1:0] key,
         input logic [ksqt_pkg::WORD_W-1:0] price);
      table_result_type res;
      int               pos;
      res.hit   = 1'b0;
      res.id    = ksqt_pkg::NONE_ID;
      res.price = '0;
      res.ovf   = 1'b0;
      case (func)
         ksqt_pkg::FN_PUSH, ksqt_pkg::FN_APPEND: begin
            if (held_count >= ksqt_pkg::DEPTH) begin
               res.ovf = 1'b1;
            end else if (func == ksqt_pkg::FN_PUSH) begin
               for (pos = held_count; pos > 0; pos--) begin
                  held_ids[pos]    = held_ids[pos - 1];
                  held_prices[pos] = held_prices[pos - 1];
               end
               held_ids[0]    = key;
               held_prices[0] = price;
               held_count++;
            end else begin
               held_ids[held_count]    = key;
               held_prices[held_count] = price;
               held_count++;
            end
         end
         ksqt_pkg::FN_POP: begin
            if (held_count > 0) begin
               take_entry(0, res);
            end
         end
         ksqt_pkg::FN_REMOVE: begin
            // first match from the front only
            for (pos = 0; pos < held_count && !res.hit; pos++) begin
               if (held_ids[pos] == key) begin
                  take_entry(pos, res);
               end
            end
         end
         default: begin
            res.ovf = 1'b0;
         end
      endcase
      res.occ = ksqt_pkg::OCC_W'(held_count);
      return res;
   endfunction

   // Results are checked before the same edge's request is predicted:
   // a result can never belong to a request accepted on the same edge.
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report($sformatf("result word %0d arrived with no request waiting",
                                rsp_index));
            end else begin
               want = pending_results.pop_front();
               if (rsp_hit !== want.hit)
                  report($sformatf("word %0d hit: got %b want %b",
                                   rsp_index, rsp_hit, want.hit));
               if (rsp_out_id !== want.id)
                  report($sformatf("word %0d out_id: got %h want %h",
                                   rsp_index, rsp_out_id, want.id));
               if (rsp_out_price_bits !== want.price)
                  report($sformatf("word %0d out_price_bits: got %h want %h",
                                   rsp_index, rsp_out_price_bits, want.price));
               if (rsp_overflow !== want.ovf)
                  report($sformatf("word %0d overflow: got %b want %b",
                                   rsp_index, rsp_overflow, want.ovf));
               if (rsp_occupancy !== want.occ)
                  report($sformatf("word %0d occupancy: got %0d want %0d",
                                   rsp_index, rsp_occupancy, want.occ));
            end
            rsp_index++;
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(apply_request(req_func, req_key_id,
                                                    req_price_bits));
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

### sim/tb_keyed_stack_queue_table.sv
// ----------------------------------------------------------------------------
// tb_keyed_stack_queue_table
// Drives directed and random request words into the keyed stack/queue table
// with bursty sending and a stalling receiver; the checker beside the block
// predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keyed_stack_queue_table;

   localparam int RANDOM_WORDS = 700;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 40;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [ksqt_pkg::FUNC_W-1:0]         req_func;
   logic signed [ksqt_pkg::WORD_W-1:0]  req_key_id;
   logic [ksqt_pkg::WORD_W-1:0]         req_price_bits;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic                                rsp_hit;
   logic signed [ksqt_pkg::WORD_W-1:0]  rsp_out_id;
   logic [ksqt_pkg::WORD_W-1:0]         rsp_out_price_bits;
   logic                                rsp_overflow;
   logic [ksqt_pkg::OCC_W-1:0]          rsp_occupancy;

   int                        fail_count;
   int                        outstanding;
   int                        cycle_count;
   int                        ready_phase;
   int                        stall_left;

   keyed_stack_queue_table i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_key_id         (req_key_id),
      .req_price_bits     (req_price_bits),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_price_bits (rsp_out_price_bits),
      .rsp_overflow       (rsp_overflow),
      .rsp_occupancy      (rsp_occupancy)
   );

   ksqt_table_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_key_id         (req_key_id),
      .req_price_bits     (req_price_bits),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_price_bits (rsp_out_price_bits),
      .rsp_overflow       (rsp_overflow),
      .rsp_occupancy      (rsp_occupancy),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // Clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Known values on every input from time zero
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = ksqt_pkg::FN_PUSH;
      req_key_id     = '0;
      req_price_bits = '0;
      rsp_ready      = 1'b0;
      cycle_count    = 0;
      ready_phase    = 0;
      stall_left     = 0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: stall pattern steps through four modes as the phase counter runs
   always @(negedge clock) begin
      ready_phase++;
      case ((ready_phase >> 7) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 9) != 0);
         default: begin
            // long stalls now and then
            if (stall_left != 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
            end
         end
      endcase
   end

   // Present one word and hold it until accepted
   task automatic send_word(input logic [ksqt_pkg::FUNC_W-1:0] func,
                            input logic [ksqt_pkg::WORD_W-1:0] key,
                            input logic [ksqt_pkg::WORD_W-1:0] price);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_key_id     <= key;
      req_price_bits <= price;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
   endtask

   // Sender gap: keep req_valid low
   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop sending until every result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Keys mostly from a small pool so removals find something
   function automatic logic [ksqt_pkg::WORD_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return ksqt_pkg::WORD_W'($urandom_range(0, 7));
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return ksqt_pkg::NONE_ID;
            default: return '0;
         endcase
      end
      return $urandom;
   endfunction

   // Request code weighted by the current fill/drain mode
   function automatic logic [ksqt_pkg::FUNC_W-1:0] pick_func(input int mode);
      int r;
      int insert_pct;
      r = $urandom_range(0, 99);
      case (mode)
         0: insert_pct = 75;
         1: insert_pct = 50;
         default: insert_pct = 25;
      endcase
      if (r < insert_pct) begin
         return ($urandom_range(0, 1) != 0) ? ksqt_pkg::FN_APPEND : ksqt_pkg::FN_PUSH;
      end
      return ($urandom_range(0, 1) != 0) ? ksqt_pkg::FN_REMOVE : ksqt_pkg::FN_POP;
   endfunction

   // Stimulus
   initial begin
      int i;
      int mode;
      int burst_left;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty store misses
      send_word(ksqt_pkg::FN_POP,    32'd0,         32'd0);
      send_word(ksqt_pkg::FN_REMOVE, 32'd7,         32'd0);
      // field extremes; remove of the id that equals the miss value
      send_word(ksqt_pkg::FN_PUSH,   32'h8000_0000, 32'h0000_0000);
      send_word(ksqt_pkg::FN_APPEND, 32'h7fff_ffff, 32'hffff_ffff);
      send_word(ksqt_pkg::FN_PUSH,   ksqt_pkg::NONE_ID, 32'h1234_5678);
      send_word(ksqt_pkg::FN_REMOVE, ksqt_pkg::NONE_ID, 32'h0);
      // duplicate ids: only the front one goes
      send_word(ksqt_pkg::FN_APPEND, 32'd5,         32'haaaa_aaaa);
      send_word(ksqt_pkg::FN_PUSH,   32'd5,         32'h5555_5555);
      send_word(ksqt_pkg::FN_REMOVE, 32'd5,         32'h0);
      // fill to full
      for (i = 0; i < 13; i++) begin
         send_word((i % 2 != 0) ? ksqt_pkg::FN_APPEND : ksqt_pkg::FN_PUSH,
                   32'h100 + i, $urandom);
      end
      // inserts into a full store are dropped
      send_word(ksqt_pkg::FN_PUSH,   32'h200,       32'hdead_beef);
      send_word(ksqt_pkg::FN_APPEND, 32'h201,       32'hcafe_f00d);
      // match in the back slot, then no match at all
      send_word(ksqt_pkg::FN_REMOVE, 32'h10b,       32'h0);
      send_word(ksqt_pkg::FN_REMOVE, 32'hdead,      32'h0);
      send_word(ksqt_pkg::FN_POP,    32'd0,         32'd0);

      // Random part: bursts with gaps, fill/drain modes
      mode       = 1;
      burst_left = 0;
      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 40 == 0) mode = $urandom_range(0, 2);
         if (i == RANDOM_WORDS / 2) wait_drained();
         if (burst_left == 0) begin
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
         send_word(pick_func(mode), pick_key(), $urandom);
      end

      // Drain and let the block settle
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
design/ksqt_pkg.sv
design/ksqt_dp.sv
design/ksqt_ctrl.sv
design/keyed_stack_queue_table.sv
design/ksqt_checker.sv
sim/ksqt_table_checker.sv
sim/tb_keyed_stack_queue_table.sv
